[src/pvmd_pkg.sv]
// ----------------------------------------------------------------------------
// pvmd_pkg
// shared widths, register indexes and constants of the velocity pid core
// ----------------------------------------------------------------------------
package pvmd_pkg;

  localparam int SPEED_W   = 20;
  localparam int ERR_W     = 21;
  localparam int SUM_W     = 25;
  localparam int DIFF_W    = 22;
  localparam int OPND_W    = 26;
  localparam int GAIN_W    = 16;
  localparam int ILIM_W    = 24;
  localparam int ACC_W     = 43;
  localparam int FRAC_W    = 12;
  localparam int NUM_W     = ACC_W - 1 - FRAC_W;
  localparam int DIV_W     = 16;
  localparam int OUT_W     = 17;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam int COMPARE_CHANNEL = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_REV     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_REV   = 3'd7;

  typedef struct packed {
    logic                    start;
    logic [NUM_W-1:0]        dividend;
    logic [DIV_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [NUM_W-1:0]        quotient;
  } div_rsp_t;

endpackage

[src/pvmd_if.sv]
// ----------------------------------------------------------------------------
// pvmd_if
// valid/ready channels carrying speed samples in and controller results out
// ----------------------------------------------------------------------------
interface pvmd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pvmd_pkg::SPEED_W-1:0]    target_speed;
  logic signed [pvmd_pkg::SPEED_W-1:0]    measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface pvmd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pvmd_pkg::OUT_W-1:0]      control_output;
  logic                                   direction_pin;
  logic [pvmd_pkg::DIV_W-1:0]             duty_compare;

  modport source (output valid, output control_output, output direction_pin,
                  output duty_compare, input ready);
  modport sink   (input valid, input control_output, input direction_pin,
                  input duty_compare, output ready);
endinterface

[src/pvmd_divider.sv]
// ----------------------------------------------------------------------------
// pvmd_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pvmd_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  pvmd_pkg::div_req_t  req,
  output pvmd_pkg::div_rsp_t  rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [pvmd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pvmd_pkg::DIV_W-1:0]    rem_r, rem_nxt;
  logic [pvmd_pkg::DIV_W-1:0]    den_r, den_nxt;
  logic [pvmd_pkg::NUM_W-1:0]    quo_r, quo_nxt;
  logic [pvmd_pkg::DIV_W:0]      shifted;
  logic                          fits;

  assign shifted = {rem_r, quo_r[pvmd_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(shifted - {1'b0, den_r}) : shifted[pvmd_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[pvmd_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pvmd_pkg::CNT_W'(pvmd_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[src/pid_velocity_motor_drive_core.sv]
// ----------------------------------------------------------------------------
// pid_velocity_motor_drive_core
// velocity pid with integral clamp, output clamp and direction pin
// ----------------------------------------------------------------------------
// usage:
//   in_ch  : one transaction per control period, target and measured speed
//   out_ch : one transaction per input, signed output, pin level, compare value
//   cfg_*  : register writes, only while no transaction is in flight
// datapath: error, integral, products, accumulate, magnitude, divide, output;
//   the serial divider yields one quotient bit per cycle, the shared
//   multiplier one gain product per cycle
// intake: in_ch.ready is high only while the sequencer is idle, so a new
//   transaction is taken only once the previous one has left the sequencer
// reset: gains, limits and flags go to their defaults, the error integral and
//   the previous error clear, no result is pending
// stall: the result sits in an output register; the next input is taken
//   while it waits, and that item holds before its final step until out_ch
//   is drained
// ----------------------------------------------------------------------------
module pid_velocity_motor_drive_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pvmd_in_if.sink                              in_ch,
  pvmd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [pvmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pvmd_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_INT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_MAG  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int ERR_W  = pvmd_pkg::ERR_W;
  localparam int DIFF_W = pvmd_pkg::DIFF_W;
  localparam int OPND_W = pvmd_pkg::OPND_W;
  localparam int ACC_W  = pvmd_pkg::ACC_W;

  // configuration
  logic [pvmd_pkg::GAIN_W-1:0]  kp_r, ki_r, kd_r, gdiv_r;
  logic [pvmd_pkg::ILIM_W-1:0]  ilim_r;
  logic [pvmd_pkg::DIV_W-1:0]   olim_r;
  logic                         enc_rev_r, mot_rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= 16'd256;
      ki_r      <= '0;
      kd_r      <= '0;
      gdiv_r    <= 16'd1;
      ilim_r    <= '1;
      olim_r    <= '1;
      enc_rev_r <= 1'b0;
      mot_rev_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvmd_pkg::REG_PROP_GAIN:  kp_r      <= cfg_wdata[15:0];
        pvmd_pkg::REG_INT_GAIN:   ki_r      <= cfg_wdata[15:0];
        pvmd_pkg::REG_DERIV_GAIN: kd_r      <= cfg_wdata[15:0];
        pvmd_pkg::REG_GAIN_DIV:   gdiv_r    <= cfg_wdata[15:0];
        pvmd_pkg::REG_INT_LIMIT:  ilim_r    <= cfg_wdata[23:0];
        pvmd_pkg::REG_OUT_LIMIT:  olim_r    <= cfg_wdata[15:0];
        pvmd_pkg::REG_ENC_REV:    enc_rev_r <= cfg_wdata[0];
        pvmd_pkg::REG_MOTOR_REV:  mot_rev_r <= cfg_wdata[0];
      endcase
    end
  end

  // sequencer and datapath registers
  logic [2:0]                              state_r, state_nxt;
  logic [1:0]                              mcnt_r, mcnt_nxt;
  logic signed [pvmd_pkg::SPEED_W-1:0]     tgt_r, meas_r;
  logic signed [pvmd_pkg::ERR_W-1:0]       e_r, e_nxt;
  logic signed [pvmd_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [pvmd_pkg::ERR_W-1:0]       prev_r, prev_nxt;
  logic signed [pvmd_pkg::DIFF_W-1:0]      diff_r, diff_nxt;
  logic signed [pvmd_pkg::ACC_W-1:0]       prod_r, prod_nxt;
  logic signed [pvmd_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic                                    neg_r, neg_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic signed [pvmd_pkg::OUT_W-1:0]       out_ctrl_r, out_ctrl_nxt;
  logic                                    out_pin_r, out_pin_nxt;
  logic [pvmd_pkg::DIV_W-1:0]              out_duty_r, out_duty_nxt;

  logic                                    in_fire, out_fire;
  pvmd_pkg::div_req_t                      div_req;
  pvmd_pkg::div_rsp_t                      div_rsp;

  // error stage
  logic signed [pvmd_pkg::ERR_W-1:0]       tgt_x;
  logic signed [pvmd_pkg::DIFF_W-1:0]      e_raw;
  // integral stage
  logic signed [pvmd_pkg::OPND_W-1:0]      sum_raw, lim_pos;
  // shared multiplier
  logic [pvmd_pkg::GAIN_W-1:0]             mul_a;
  logic signed [pvmd_pkg::OPND_W-1:0]      mul_b;
  logic signed [pvmd_pkg::ACC_W-1:0]       mag;
  // output stage
  logic [pvmd_pkg::DIV_W-1:0]              q_cl;
  logic                                    neg_f;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    tgt_x = enc_rev_r ? -ERR_W'(tgt_r) : ERR_W'(tgt_r);
    e_raw = DIFF_W'(tgt_x) - DIFF_W'(meas_r);
  end

  assign sum_raw = OPND_W'(sum_r) + OPND_W'(e_r);
  assign lim_pos = OPND_W'(signed'({1'b0, ilim_r}));

  always_comb begin
    unique case (mcnt_r)
      2'd0: begin
        mul_a = kp_r;
        mul_b = OPND_W'(e_r);
      end
      2'd1: begin
        mul_a = ki_r;
        mul_b = OPND_W'(sum_r);
      end
      default: begin
        mul_a = kd_r;
        mul_b = OPND_W'(diff_r);
      end
    endcase
  end

  assign mag = acc_r[ACC_W-1] ? -acc_r : acc_r;

  assign q_cl  = (div_rsp.quotient > pvmd_pkg::NUM_W'(olim_r)) ? olim_r
               : div_rsp.quotient[pvmd_pkg::DIV_W-1:0];
  assign neg_f = neg_r && (olim_r != '0);

  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    e_nxt         = e_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_ctrl_nxt  = out_ctrl_r;
    out_pin_nxt   = out_pin_r;
    out_duty_nxt  = out_duty_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag[ACC_W-2:pvmd_pkg::FRAC_W];
    div_req.divisor  = (gdiv_r == '0) ? 16'd1 : gdiv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_ERR;
      end
      S_ERR: begin
        // saturate to the 21 bit error range
        if (e_raw > DIFF_W'(signed'({2'b0, {(ERR_W-1){1'b1}}})))
          e_nxt = {1'b0, {(ERR_W-1){1'b1}}};
        else if (e_raw < DIFF_W'(signed'({2'b11, {(ERR_W-1){1'b0}}})))
          e_nxt = {1'b1, {(ERR_W-1){1'b0}}};
        else
          e_nxt = e_raw[ERR_W-1:0];
        state_nxt = S_INT;
      end
      S_INT: begin
        if (sum_raw > lim_pos)       sum_nxt = pvmd_pkg::SUM_W'(lim_pos);
        else if (sum_raw < -lim_pos) sum_nxt = pvmd_pkg::SUM_W'(-lim_pos);
        else                         sum_nxt = pvmd_pkg::SUM_W'(sum_raw);
        diff_nxt  = DIFF_W'(e_r) - DIFF_W'(prev_r);
        prev_nxt  = e_r;
        mcnt_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = ACC_W'(signed'({1'b0, mul_a})) * ACC_W'(mul_b);
        acc_nxt  = (mcnt_r == 2'd0) ? '0 : acc_r + prod_r;
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = acc_r + prod_r;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        neg_nxt       = acc_r[ACC_W-1];
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_fire) begin
          out_valid_nxt = 1'b1;
          out_ctrl_nxt  = neg_f ? -signed'({1'b0, q_cl}) : signed'({1'b0, q_cl});
          out_pin_nxt   = neg_f ^ enc_rev_r ^ mot_rev_r;
          out_duty_nxt  = (pvmd_pkg::COMPARE_CHANNEL >= 1 && pvmd_pkg::COMPARE_CHANNEL <= 4)
                        ? q_cl : '0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r  <= in_ch.target_speed;
      meas_r <= in_ch.measured_speed;
    end
    e_r        <= e_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    out_ctrl_r <= out_ctrl_nxt;
    out_pin_r  <= out_pin_nxt;
    out_duty_r <= out_duty_nxt;
  end

  pvmd_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.control_output = out_ctrl_r;
  assign out_ch.direction_pin  = out_pin_r;
  assign out_ch.duty_compare   = out_duty_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_accept_starts_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_ERR)
    else $error("accepted transaction did not start the error step");

  a_duty_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_compare <= olim_r)
    else $error("compare value above the output limit");

endmodule
